@@ rtl/core/tam_pkg.sv @@
`timescale 1ns / 1ps

package tam_pkg;

    typedef logic [1:0] level_t;

    localparam level_t LVL_NORMAL   = 2'd0;
    localparam level_t LVL_LIGHT    = 2'd1;
    localparam level_t LVL_MODERATE = 2'd2;
    localparam level_t LVL_CRITICAL = 2'd3;

    // Excursion limits in 1/16 degree (5 and 10 degrees)
    localparam logic signed [17:0] LIGHT_LIMIT    = 18'sd80;
    localparam logic signed [17:0] MODERATE_LIMIT = 18'sd160;

    localparam logic [15:0] RUN_MAX = 16'hFFFF;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_WINDOW_LOW  = 2'd0;
    localparam reg_idx_t REG_WINDOW_HIGH = 2'd1;
    localparam reg_idx_t REG_ALARM_RUN   = 2'd2;

    localparam logic [11:0] WINDOW_LOW_RST  = 12'd0;
    localparam logic [11:0] WINDOW_HIGH_RST = 12'd50;
    localparam logic [15:0] ALARM_RUN_RST   = 16'd3;

endpackage

@@ rtl/core/temperature_alert_monitor_unit.sv @@
`timescale 1ns / 1ps

// Temperature alert monitor.
// Input channel: in_valid/in_ready with sample_temp (signed, 1/16 degree).
// Output channel: out_valid/out_ready with the alert level, run length, alarm
// and the running statistics (min, max, sum, sample count, per-level counts).
// Configuration: APB-style port, window_low at 0x0, window_high at 0x4,
// alarm_run_length at 0x8; pready is tied high. Write only while idle.
// Path: input register, then grading and statistics update into the result
// register. Throughput: one item per cycle while out_ready holds; the grade,
// window compare and the 32-bit sum update all sit in the single stage between
// the two registers.
// Reset clears the run counter, statistics and both valid flags and loads the
// register defaults (0, 50, 3).
// When the receiver stalls, the result stays held, the input register fills,
// and in_ready drops until the result is taken. Once MAX_SAMPLES samples are
// counted the statistics freeze; level, run and alarm keep updating.
module temperature_alert_monitor_unit #(
    parameter logic [15:0] MAX_SAMPLES = 16'd65535
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample_temp,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         alert_level,
    output logic [15:0]        run_length,
    output logic               alarm,
    output logic signed [15:0] lowest_temp,
    output logic signed [15:0] highest_temp,
    output logic signed [31:0] temp_total,
    output logic [15:0]        samples_seen,
    output logic [15:0]        light_count,
    output logic [15:0]        moderate_count,
    output logic [15:0]        critical_count
);

    logic signed [11:0] window_low_reg;
    logic signed [11:0] window_high_reg;
    logic [15:0]        alarm_run_reg;

    logic               in_valid_reg;
    logic signed [15:0] sample_reg;

    logic               out_valid_reg;
    tam_pkg::level_t    level_reg;
    logic               alarm_reg;
    logic [15:0]        run_reg;
    logic signed [15:0] min_reg;
    logic signed [15:0] max_reg;
    logic signed [31:0] sum_reg;
    logic [15:0]        tally_reg;
    logic [15:0]        light_reg;
    logic [15:0]        moderate_reg;
    logic [15:0]        critical_reg;

    logic               advance;
    logic               cfg_write;
    tam_pkg::reg_idx_t  cfg_idx;

    logic signed [17:0] s_x;
    logic signed [17:0] lo_x;
    logic signed [17:0] hi_x;
    logic signed [17:0] gap;
    logic               above;
    logic               below;
    tam_pkg::level_t    level_next;
    logic [15:0]        run_next;
    logic               alarm_next;
    logic               counting;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= tam_pkg::WINDOW_LOW_RST;
            window_high_reg <= tam_pkg::WINDOW_HIGH_RST;
            alarm_run_reg   <= tam_pkg::ALARM_RUN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                tam_pkg::REG_WINDOW_LOW:  window_low_reg  <= pwdata[11:0];
                tam_pkg::REG_WINDOW_HIGH: window_high_reg <= pwdata[11:0];
                tam_pkg::REG_ALARM_RUN:   alarm_run_reg   <= pwdata[15:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tam_pkg::REG_WINDOW_LOW:  prdata = {20'd0, window_low_reg};
            tam_pkg::REG_WINDOW_HIGH: prdata = {20'd0, window_high_reg};
            tam_pkg::REG_ALARM_RUN:   prdata = {16'd0, alarm_run_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sample_reg <= sample_temp;
        end
    end

    // ---------------- grading ----------------
    always_comb
    begin
        s_x   = {{2{sample_reg[15]}}, sample_reg};
        lo_x  = {{2{window_low_reg[11]}}, window_low_reg, 4'b0000};
        hi_x  = {{2{window_high_reg[11]}}, window_high_reg, 4'b0000};
        above = s_x > hi_x;
        below = s_x < lo_x;
        // an inverted window always lands in one of the two branches
        gap   = above ? (s_x - hi_x) : (lo_x - s_x);

        if (!above && !below)
        begin
            level_next = tam_pkg::LVL_NORMAL;
        end
        else if (gap < tam_pkg::LIGHT_LIMIT)
        begin
            level_next = tam_pkg::LVL_LIGHT;
        end
        else if (gap < tam_pkg::MODERATE_LIMIT)
        begin
            level_next = tam_pkg::LVL_MODERATE;
        end
        else
        begin
            level_next = tam_pkg::LVL_CRITICAL;
        end

        if (level_next == tam_pkg::LVL_NORMAL)
        begin
            run_next = 16'd0;
        end
        else if (run_reg != tam_pkg::RUN_MAX)
        begin
            run_next = run_reg + 16'd1;
        end
        else
        begin
            run_next = run_reg;
        end

        alarm_next = (level_next != tam_pkg::LVL_NORMAL) && (run_next >= alarm_run_reg);
        counting   = tally_reg < MAX_SAMPLES;
    end

    // ---------------- state and result ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 16'd0;
            min_reg      <= 16'sd0;
            max_reg      <= 16'sd0;
            sum_reg      <= 32'sd0;
            tally_reg    <= 16'd0;
            light_reg    <= 16'd0;
            moderate_reg <= 16'd0;
            critical_reg <= 16'd0;
        end
        else if (advance)
        begin
            run_reg <= run_next;
            if (counting)
            begin
                if (tally_reg == 16'd0 || sample_reg < min_reg)
                begin
                    min_reg <= sample_reg;
                end
                if (tally_reg == 16'd0 || sample_reg > max_reg)
                begin
                    max_reg <= sample_reg;
                end
                sum_reg   <= sum_reg + {{16{sample_reg[15]}}, sample_reg};
                tally_reg <= tally_reg + 16'd1;
                case (level_next)
                    tam_pkg::LVL_LIGHT:    light_reg    <= light_reg + 16'd1;
                    tam_pkg::LVL_MODERATE: moderate_reg <= moderate_reg + 16'd1;
                    tam_pkg::LVL_CRITICAL: critical_reg <= critical_reg + 16'd1;
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg <= level_next;
            alarm_reg <= alarm_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign alert_level    = level_reg;
    assign alarm          = alarm_reg;
    assign run_length     = run_reg;
    assign lowest_temp    = min_reg;
    assign highest_temp   = max_reg;
    assign temp_total     = sum_reg;
    assign samples_seen   = tally_reg;
    assign light_count    = light_reg;
    assign moderate_count = moderate_reg;
    assign critical_count = critical_reg;

    // ---------------- assertions ----------------
    a_alarm_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && alarm_reg |-> level_reg != tam_pkg::LVL_NORMAL)
        else $error("alarm raised on a normal sample");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && level_reg == tam_pkg::LVL_NORMAL |-> run_reg == 16'd0)
        else $error("run counter not cleared by normal sample");

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= MAX_SAMPLES)
        else $error("sample count beyond limit");

    a_level_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ({2'b00, light_reg} + {2'b00, moderate_reg} + {2'b00, critical_reg})
            <= {2'b00, tally_reg})
        else $error("level counts exceed sample count");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg == MAX_SAMPLES |=> $stable(sum_reg) && $stable(tally_reg))
        else $error("statistics changed after freeze");

endmodule
